// ----- hdl/mnva_pkg.sv -----
// Shared types, constants and the pitch table for the MIDI note voice allocator.
// No dependencies; every other file in hdl/ imports this package.
package mnva_pkg;

   localparam int DEFAULT_NUM_VOICES = 4;
   localparam int MAX_RESULTS        = 4;
   localparam int RSP_FIFO_DEPTH     = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_RX_CHANNEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY_MODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_SENSE  = 2'd2;

   localparam logic [7:0]  FREE_SLOT = 8'd255;
   localparam logic [6:0]  FULL_LEVEL = 7'd127;
   localparam logic [20:0] FREQ_MIN  = 21'd5120;
   localparam logic [20:0] FREQ_MAX  = 21'd2048000;
   localparam logic [63:0] A4_Q8     = 64'd112640;

   typedef struct packed {
      logic       op;
      logic [4:0] channel;
      logic [6:0] note;
      logic [6:0] velocity;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  voice;
      logic        is_poly;
      logic        gate;
      logic [20:0] frequency;
      logic [6:0]  level;
      logic        takes_gate_source;
      logic        last;
   } rsp_payload_type;

   // request token walking the voice cell chain
   typedef struct packed {
      logic       valid;
      logic       act_on;
      logic       act_off;
      logic [6:0] note;
      logic       any_free;
      logic       claimed;
   } probe_type;

   typedef struct packed {
      logic valid;
      logic gate;
   } hit_type;

   // A4 in Q8 times the Q30 semitone ratio
   function automatic logic [47:0] freq_base(input logic [3:0] semi);
      logic [47:0] r;
      begin
         case (semi)
            4'd0:    r = 48'(A4_Q8 * 64'd1073741824);
            4'd1:    r = 48'(A4_Q8 * 64'd1137589835);
            4'd2:    r = 48'(A4_Q8 * 64'd1205234447);
            4'd3:    r = 48'(A4_Q8 * 64'd1276901417);
            4'd4:    r = 48'(A4_Q8 * 64'd1352829926);
            4'd5:    r = 48'(A4_Q8 * 64'd1433273380);
            4'd6:    r = 48'(A4_Q8 * 64'd1518500250);
            4'd7:    r = 48'(A4_Q8 * 64'd1608794974);
            4'd8:    r = 48'(A4_Q8 * 64'd1704458901);
            4'd9:    r = 48'(A4_Q8 * 64'd1805811301);
            4'd10:   r = 48'(A4_Q8 * 64'd1913190429);
            4'd11:   r = 48'(A4_Q8 * 64'd2026954652);
            default: r = 48'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- hdl/mnva_voice_cell.sv -----
// One voice slot of the allocator chain: holds the slot note and passes the probe on.
// Depends on mnva_pkg.
module mnva_voice_cell
   import mnva_pkg::*;
#(
   parameter int VOICE_W = 2,
   parameter int IDX     = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  probe_type          probe_in,
   input  logic [VOICE_W-1:0] steal_ptr,
   output probe_type          probe_out,
   output hit_type            hit,
   output logic               free
);

   logic [7:0] note_ff, note_in;
   probe_type  probe_ff, probe_in_next;
   logic       take, rel;

   assign free = (note_ff == FREE_SLOT);

   always_comb begin
      take = probe_in.valid && probe_in.act_on &&
             ((probe_in.any_free && free && !probe_in.claimed) ||
              (!probe_in.any_free && steal_ptr == VOICE_W'(IDX)));
      rel  = probe_in.valid && probe_in.act_off && (note_ff == {1'b0, probe_in.note});
      note_in = note_ff;
      if (take) begin
         note_in = {1'b0, probe_in.note};
      end else if (rel) begin
         note_in = FREE_SLOT;
      end
      probe_in_next = probe_in;
      probe_in_next.claimed = probe_in.claimed | take;
      hit.valid = take | rel;
      hit.gate  = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff        <= FREE_SLOT;
         probe_ff.valid <= 1'b0;
      end else begin
         note_ff        <= note_in;
         probe_ff.valid <= probe_in_next.valid;
      end
      probe_ff.act_on   <= probe_in_next.act_on;
      probe_ff.act_off  <= probe_in_next.act_off;
      probe_ff.note     <= probe_in_next.note;
      probe_ff.any_free <= probe_in_next.any_free;
      probe_ff.claimed  <= probe_in_next.claimed;
   end

   assign probe_out = probe_ff;

endmodule

// ----- hdl/mnva_pitch.sv -----
// Two-stage note to Q13.8 frequency unit: octave split, then table, round and clamp.
// Depends on mnva_pkg.
module mnva_pitch
   import mnva_pkg::*;
(
   input  logic        clock,
   input  logic [6:0]  note_in,
   output logic [20:0] freq_out
);

   logic [7:0]  t;
   logic [15:0] prod;
   logic [3:0]  oct;
   logic [3:0]  semi;
   logic [3:0]  oct_ff, semi_ff;
   logic [5:0]  sh;
   logic [48:0] sum, shifted;
   logic [20:0] freq_in, freq_ff;

   always_comb begin
      t    = 8'(note_in) + 8'd3;
      // t / 12 for t <= 130
      prod = 16'(t) * 16'd171;
      oct  = prod[14:11];
      semi = 4'(t - 8'(oct) * 8'd12);
   end

   always_comb begin
      sh      = 6'd36 - 6'(oct_ff);
      sum     = 49'(freq_base(semi_ff)) + (49'd1 << (sh - 6'd1));
      shifted = sum >> sh;
      if (shifted < 49'(FREQ_MIN)) begin
         freq_in = FREQ_MIN;
      end else if (shifted > 49'(FREQ_MAX)) begin
         freq_in = FREQ_MAX;
      end else begin
         freq_in = shifted[20:0];
      end
   end

   always_ff @(posedge clock) begin
      oct_ff  <= oct;
      semi_ff <= semi;
      freq_ff <= freq_in;
   end

   assign freq_out = freq_ff;

endmodule

// ----- hdl/midi_note_voice_allocator_core.sv -----
// MIDI note voice allocator top level: control, mono state, voice cell chain, result queue.
// Depends on mnva_pkg, mnva_voice_cell and mnva_pitch.
// Flow: a request is accepted, ST_PREP launches a probe, then in ST_SCAN the probe walks
// the voice cell chain one cell per cycle and leaves it in an exit cycle. The last result
// is queued in the exit cycle and reaches rsp through the result FIFO and the rsp register
// when the output is free. A request failing the channel filter is dropped with no result.
// New requests stall while one is in progress or the FIFO has room for under MAX_RESULTS.
// Reset (synchronous): all slots free, steal pointer 0, no mono note, control registers cleared.
module midi_note_voice_allocator_core
   import mnva_pkg::*;
#(
   parameter int NUM_VOICES = DEFAULT_NUM_VOICES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int PTR_W   = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W   = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int TOT_W   = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PREP = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [4:0] rx_channel_ff, rx_channel_in;
   logic       poly_mode_ff, poly_mode_in;
   logic       vel_sense_ff, vel_sense_in;

   req_payload_type req_ff;
   logic [6:0]      level_ff;
   logic [7:0]      mono_note_ff, mono_note_in;
   logic [VOICE_W-1:0] steal_ptr_ff, steal_ptr_in;
   logic [VOICE_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [TOT_W-1:0]   total_ff, total_in;

   probe_type launch_ff, launch_in;
   probe_type chain [NUM_VOICES+1];
   hit_type   hits [NUM_VOICES];
   logic [NUM_VOICES-1:0] free_vec;
   logic       hit_any, hit_gate;

   rsp_payload_type pend_ff, pend_in;
   logic            pend_valid_ff, pend_valid_in;

   rsp_payload_type fifo_mem [RSP_FIFO_DEPTH];
   rsp_payload_type push_data;
   rsp_payload_type rsp_ff;
   logic             rsp_valid_ff;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, push_last, pop, load;

   logic [20:0] freq;
   logic        accept, filtered, is_off;

   mnva_pitch u_pitch (
      .clock    (clock),
      .note_in  (req_ff.note),
      .freq_out (freq)
   );

   assign chain[0] = launch_ff;

   for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
      mnva_voice_cell #(
         .VOICE_W (VOICE_W),
         .IDX     (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[i]),
         .steal_ptr (steal_ptr_ff),
         .probe_out (chain[i+1]),
         .hit       (hits[i]),
         .free      (free_vec[i])
      );
   end

   always_comb begin
      hit_any  = 1'b0;
      hit_gate = 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         hit_any  = hit_any | hits[i].valid;
         hit_gate = hit_gate | hits[i].gate;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) ||
                      (count_ff > CNT_W'(RSP_FIFO_DEPTH - MAX_RESULTS));
   assign accept    = req_valid && !req_stall;
   assign filtered  = (rx_channel_ff != 5'd0) && (req_payload.channel != rx_channel_ff);
   assign is_off    = req_ff.op || (req_ff.velocity == 7'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign load      = (count_ff != '0) && (!rsp_valid_ff || pop);

   always_comb begin
      rx_channel_in = rx_channel_ff;
      poly_mode_in  = poly_mode_ff;
      vel_sense_in  = vel_sense_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RX_CHANNEL: rx_channel_in = csr_wdata;
            CSR_POLY_MODE:  poly_mode_in  = csr_wdata[0];
            CSR_VEL_SENSE:  vel_sense_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      mono_note_in  = mono_note_ff;
      steal_ptr_in  = steal_ptr_ff;
      scan_cnt_in   = scan_cnt_ff;
      total_in      = total_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      push          = 1'b0;
      push_last     = 1'b0;

      launch_in          = launch_ff;
      launch_in.valid    = 1'b0;
      launch_in.act_on   = poly_mode_ff && !is_off;
      launch_in.act_off  = poly_mode_ff && is_off;
      launch_in.note     = req_ff.note;
      launch_in.any_free = |free_vec;
      launch_in.claimed  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !filtered) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            launch_in.valid = 1'b1;
            scan_cnt_in     = '0;
            total_in        = '0;
            state_in        = ST_SCAN;
            if (!poly_mode_ff) begin
               pend_in.voice             = 2'd0;
               pend_in.is_poly           = 1'b0;
               pend_in.frequency         = '0;
               pend_in.last              = 1'b0;
               if (!is_off) begin
                  mono_note_in              = {1'b0, req_ff.note};
                  pend_in.gate              = 1'b1;
                  pend_in.level             = level_ff;
                  pend_in.takes_gate_source = 1'b1;
                  pend_valid_in             = 1'b1;
               end else if (mono_note_ff == {1'b0, req_ff.note}) begin
                  mono_note_in              = FREE_SLOT;
                  pend_in.gate              = 1'b0;
                  pend_in.level             = '0;
                  pend_in.takes_gate_source = 1'b0;
                  pend_valid_in             = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (chain[NUM_VOICES].valid) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
               if (chain[NUM_VOICES].act_on) begin
                  steal_ptr_in = (steal_ptr_ff == VOICE_W'(NUM_VOICES - 1)) ? '0 :
                                 steal_ptr_ff + 1'b1;
               end
            end else if (hit_any && total_ff < TOT_W'(MAX_RESULTS)) begin
               push                      = pend_valid_ff;
               pend_valid_in             = 1'b1;
               total_in                  = total_ff + 1'b1;
               pend_in.voice             = 2'(scan_cnt_ff);
               pend_in.is_poly           = 1'b1;
               pend_in.gate              = hit_gate;
               pend_in.frequency         = '0;
               pend_in.level             = hit_gate ? level_ff : 7'd0;
               pend_in.takes_gate_source = 1'b0;
               pend_in.last              = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      push_data           = pend_ff;
      push_data.frequency = pend_ff.gate ? freq : 21'd0;
      push_data.last      = push_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rx_channel_ff   <= 5'd0;
         poly_mode_ff    <= 1'b0;
         vel_sense_ff    <= 1'b0;
         mono_note_ff    <= FREE_SLOT;
         steal_ptr_ff    <= '0;
         scan_cnt_ff     <= '0;
         total_ff        <= '0;
         pend_valid_ff   <= 1'b0;
         launch_ff.valid <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rx_channel_ff   <= rx_channel_in;
         poly_mode_ff    <= poly_mode_in;
         vel_sense_ff    <= vel_sense_in;
         mono_note_ff    <= mono_note_in;
         steal_ptr_ff    <= steal_ptr_in;
         scan_cnt_ff     <= scan_cnt_in;
         total_ff        <= total_in;
         pend_valid_ff   <= pend_valid_in;
         launch_ff.valid <= launch_in.valid;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (load) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !load) begin
            count_ff <= count_ff + 1'b1;
         end else if (load && !push) begin
            count_ff <= count_ff - 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      launch_ff.act_on   <= launch_in.act_on;
      launch_ff.act_off  <= launch_in.act_off;
      launch_ff.note     <= launch_in.note;
      launch_ff.any_free <= launch_in.any_free;
      launch_ff.claimed  <= launch_in.claimed;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_payload;
         level_ff <= vel_sense_ff ? req_payload.velocity : FULL_LEVEL;
      end
      pend_ff <= pend_in;
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
      if (load) begin
         rsp_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
